/* rtl/cpuu_pkg.sv */
// Shared constants and types for the cpu utilization block.
package cpuu_pkg;

   localparam int NUM_COUNTERS     = 10;
   localparam int CNT_W            = 64;
   localparam int CPU_IDX_W        = 6;
   localparam int UTIL_W           = 14;
   localparam int PROD_W           = CNT_W + UTIL_W;
   localparam int COUNTERS_W       = NUM_COUNTERS * CNT_W;
   localparam int SLOT_W           = 4;
   localparam int DEFAULT_NUM_CPUS = 64;
   localparam int REQ_TDATA_W      = ((CPU_IDX_W + COUNTERS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W      = ((CPU_IDX_W + UTIL_W + 7) / 8) * 8;

   localparam logic [UTIL_W-1:0] FULL_SCALE = 14'd10000;

   // Counter positions within one snapshot
   localparam int C_USER       = 0;
   localparam int C_NICE       = 1;
   localparam int C_SYSTEM     = 2;
   localparam int C_IDLE       = 3;
   localparam int C_IOWAIT     = 4;
   localparam int C_IRQ        = 5;
   localparam int C_SOFTIRQ    = 6;
   localparam int C_STEAL      = 7;
   localparam int C_GUEST      = 8;
   localparam int C_NICE_GUEST = 9;

   typedef struct packed {
      logic              access;
      logic              set_valid;
      logic [SLOT_W-1:0] slot;
   } store_req_type;

   typedef struct packed {
      logic load_in;
      logic rotate;
      logic shift_prev;
      logic step;
   } serial_ctrl_type;

   typedef struct packed {
      logic active;
      logic done;
   } div_status_type;

endpackage

/* rtl/cpuu_store.sv */
// Previous-snapshot memory with one valid bit per processor row.
module cpuu_store import cpuu_pkg::*; #(
   parameter int NUM_CPUS = DEFAULT_NUM_CPUS,
   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1,
   localparam int ADDR_W = $clog2(NUM_CPUS * NUM_COUNTERS)
) (
   input  logic              clock,
   input  logic              reset,
   input  store_req_type     req,
   input  logic [CPU_W-1:0]  cpu,
   input  logic [CNT_W-1:0]  wr_data,
   output logic [CNT_W-1:0]  rd_data
);

   logic [CNT_W-1:0]    mem [NUM_CPUS * NUM_COUNTERS];
   logic [CNT_W-1:0]    rd_data_ff;
   logic                row_ok_ff;
   logic [NUM_CPUS-1:0] row_valid_ff, row_valid_in;
   logic [ADDR_W-1:0]   addr;

   assign addr = ADDR_W'(int'(cpu) * NUM_COUNTERS + int'(req.slot));

   // Read returns the old entry when the same address is written
   always_ff @(posedge clock) begin
      if (req.access) begin
         mem[addr]  <= wr_data;
         rd_data_ff <= mem[addr];
      end
      row_ok_ff <= row_valid_ff[cpu];
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (req.set_valid) begin
         row_valid_in[cpu] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   // A row never written reads as zero
   assign rd_data = row_ok_ff ? rd_data_ff : '0;

endmodule

/* rtl/cpuu_serial.sv */
// Bit-serial counter differences and busy/total sums, LSB first.
module cpuu_serial import cpuu_pkg::*; (
   input  logic                  clock,
   input  serial_ctrl_type       ctrl,
   input  logic [COUNTERS_W-1:0] counters_in,
   input  logic [CNT_W-1:0]      rd_data,
   output logic [CNT_W-1:0]      wr_data,
   output logic [CNT_W-1:0]      busy,
   output logic [CNT_W-1:0]      total
);

   logic [CNT_W-1:0]        cur_ff  [NUM_COUNTERS];
   logic [CNT_W-1:0]        prev_ff [NUM_COUNTERS];
   logic [NUM_COUNTERS-1:0] borrow_ff, borrow_in;
   logic [NUM_COUNTERS-1:0] diff;
   logic [2:0]              busy_carry_ff;
   logic [1:0]              total_carry_ff;
   logic [3:0]              busy_sum;
   logic [2:0]              total_sum;
   logic [CNT_W-1:0]        busy_ff, total_ff;

   always_comb begin
      logic a, b;
      for (int c = 0; c < NUM_COUNTERS; c++) begin
         a            = cur_ff[c][0];
         b            = prev_ff[c][0];
         diff[c]      = a ^ b ^ borrow_ff[c];
         borrow_in[c] = (~a & b) | (~(a ^ b) & borrow_ff[c]);
      end
      busy_sum  = 4'(diff[C_USER]) + 4'(diff[C_NICE]) + 4'(diff[C_SYSTEM])
                + 4'(diff[C_IRQ]) + 4'(diff[C_SOFTIRQ]) + 4'(diff[C_GUEST])
                + 4'(diff[C_NICE_GUEST]) + 4'(busy_carry_ff);
      total_sum = 3'(busy_sum[0]) + 3'(diff[C_IDLE]) + 3'(diff[C_IOWAIT])
                + 3'(diff[C_STEAL]) + 3'(total_carry_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_in) begin
         for (int c = 0; c < NUM_COUNTERS; c++) begin
            cur_ff[c] <= counters_in[c*CNT_W +: CNT_W];
         end
         borrow_ff      <= '0;
         busy_carry_ff  <= '0;
         total_carry_ff <= '0;
      end else if (ctrl.rotate) begin
         // present each counter in turn at slot zero for the write port
         for (int c = 0; c < NUM_COUNTERS - 1; c++) begin
            cur_ff[c] <= cur_ff[c+1];
         end
         cur_ff[NUM_COUNTERS-1] <= cur_ff[0];
      end else if (ctrl.step) begin
         for (int c = 0; c < NUM_COUNTERS; c++) begin
            cur_ff[c] <= cur_ff[c] >> 1;
         end
         borrow_ff      <= borrow_in;
         busy_carry_ff  <= busy_sum[3:1];
         total_carry_ff <= total_sum[2:1];
         busy_ff        <= {busy_sum[0], busy_ff[CNT_W-1:1]};
         total_ff       <= {total_sum[0], total_ff[CNT_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_prev) begin
         for (int c = 0; c < NUM_COUNTERS - 1; c++) begin
            prev_ff[c] <= prev_ff[c+1];
         end
         prev_ff[NUM_COUNTERS-1] <= rd_data;
      end else if (ctrl.step) begin
         for (int c = 0; c < NUM_COUNTERS; c++) begin
            prev_ff[c] <= prev_ff[c] >> 1;
         end
      end
   end

   assign wr_data = cur_ff[0];
   assign busy    = busy_ff;
   assign total   = total_ff;

endmodule

/* rtl/cpuu_divider.sv */
// Shift-add scaling by full scale and restoring division, one bit per cycle.
module cpuu_divider import cpuu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  busy,
   input  logic [CNT_W-1:0]  total,
   output div_status_type    status,
   output logic [UTIL_W-1:0] util
);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_MUL  = 3'b010,
      D_DIV  = 3'b100
   } div_state_type;

   localparam logic [SLOT_W-1:0] STEP_LAST = SLOT_W'(UTIL_W - 1);

   div_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [UTIL_W-1:0] quo_ff, quo_in;
   logic [UTIL_W-1:0] util_ff, util_in;

   logic [CNT_W-1:0]  rem_cur;
   logic [CNT_W:0]    trial, trial_diff;
   logic              ge;

   always_comb begin
      rem_cur    = (step_ff == '0) ? acc_ff[PROD_W-1:UTIL_W] : rem_ff;
      trial      = {rem_cur, acc_ff[UTIL_W-1]};
      trial_diff = trial - {1'b0, total};
      ge         = trial >= {1'b0, total};
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      util_in  = util_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               if (total == '0 || busy == '0) begin
                  util_in = '0;
                  done_in = 1'b1;
               end else if (busy >= total) begin
                  util_in = FULL_SCALE;
                  done_in = 1'b1;
               end else begin
                  acc_in   = '0;
                  mcand_in = PROD_W'(busy);
                  step_in  = '0;
                  state_in = D_MUL;
               end
            end
         end
         D_MUL: begin
            if (FULL_SCALE[step_ff]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = mcand_ff << 1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = D_DIV;
            end
         end
         D_DIV: begin
            rem_in  = ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            acc_in  = acc_ff << 1;
            quo_in  = {quo_ff[UTIL_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               util_in  = {quo_ff[UTIL_W-2:0], ge};
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      util_ff  <= util_in;
   end

   assign status.active = (state_ff != D_IDLE);
   assign status.done   = done_ff;
   assign util          = util_ff;

   assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == D_IDLE)
      else $error("divider started while busy");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> util_ff <= FULL_SCALE)
      else $error("utilization above full scale");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == D_IDLE)
      else $error("division finished while still running");

endmodule

/* rtl/cpu_utilization_from_counters.sv */
// A snapshot beat passes through memory read/write, bit-serial differencing, then
// scale and divide; scale and divide are skipped when busy or total is zero or busy
// reaches total. One snapshot at a time: a new beat is taken only once the result
// has been loaded into the output register. Out-of-range processor beats are dropped.
// Reset clears one valid bit per processor row; an unwritten row reads as zero.
module cpu_utilization_from_counters import cpuu_pkg::*; #(
   parameter int NUM_CPUS = DEFAULT_NUM_CPUS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cpu_index, user, nice, system, idle, iowait, irq, softirq, steal, guest, niced guest
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // cpu_out, utilization
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int SEQ_W = $clog2(CNT_W);
   localparam logic [SEQ_W-1:0] LOAD_LAST   = SEQ_W'(NUM_COUNTERS);
   localparam logic [SEQ_W-1:0] SLOT_LAST   = SEQ_W'(NUM_COUNTERS - 1);
   localparam logic [SEQ_W-1:0] SERIAL_LAST = SEQ_W'(CNT_W - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_SERIAL = 5'b00100,
      ST_CALC   = 5'b01000,
      ST_HOLD   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [SEQ_W-1:0]       cnt_ff, cnt_in;
   logic                   start_ff, start_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CPU_IDX_W-1:0]   cpu_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic                   accept, cpu_ok, out_free, rsp_load;
   store_req_type          store_req;
   serial_ctrl_type        serial_ctrl;
   div_status_type         div_status;
   logic [CNT_W-1:0]       wr_data, rd_data, busy, total;
   logic [UTIL_W-1:0]      util;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cpu_ok     = int'(req_tdata[CPU_IDX_W-1:0]) < NUM_CPUS;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      start_in  = 1'b0;
      rsp_load  = 1'b0;
      store_req = '0;
      serial_ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            // drop beats for processors outside the table
            if (accept && cpu_ok) begin
               serial_ctrl.load_in = 1'b1;
               cnt_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cnt_ff != LOAD_LAST) begin
               store_req.access    = 1'b1;
               store_req.set_valid = (cnt_ff == SLOT_LAST);
               store_req.slot      = cnt_ff[SLOT_W-1:0];
               serial_ctrl.rotate  = 1'b1;
            end
            serial_ctrl.shift_prev = (cnt_ff != '0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LOAD_LAST) begin
               cnt_in   = '0;
               state_in = ST_SERIAL;
            end
         end
         ST_SERIAL: begin
            serial_ctrl.step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SERIAL_LAST) begin
               start_in = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (div_status.done) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cpu_ff <= req_tdata[CPU_IDX_W-1:0];
      end
      if (rsp_load) begin
         rsp_data_ff <= RSP_TDATA_W'({util, cpu_ff});
      end
   end

   cpuu_store #(
      .NUM_CPUS (NUM_CPUS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .cpu     (CPU_W'(cpu_ff)),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   cpuu_serial u_serial (
      .clock       (clock),
      .ctrl        (serial_ctrl),
      .counters_in (req_tdata[CPU_IDX_W +: COUNTERS_W]),
      .rd_data     (rd_data),
      .wr_data     (wr_data),
      .busy        (busy),
      .total       (total)
   );

   cpuu_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .busy   (busy),
      .total  (total),
      .status (div_status),
      .util   (util)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      (accept && cpu_ok) |=> (state_ff == ST_LOAD && !req_tready))
      else $error("in-range snapshot did not start a load");

   assert property (@(posedge clock) disable iff (reset)
      (div_status.done || div_status.active) |-> state_ff == ST_CALC)
      else $error("divider running outside calc");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(div_status.done) || $past(state_ff == ST_HOLD)))
      else $error("result beat without a finished division");

endmodule

/* test/tb.sv */
// Testbench for cpu_utilization_from_counters: random snapshot streams checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
   import cpuu_pkg::*;

   localparam int LIMIT      = 600000;
   localparam int DRAIN_WAIT = 150;
   localparam int RAND_BLOCKS = 10;
   localparam int BLOCK_ITEMS = 100;

   typedef logic [NUM_COUNTERS-1:0][CNT_W-1:0] snapshot_type;

   typedef struct packed {
      logic [CPU_IDX_W-1:0] cpu;
      logic [UTIL_W-1:0]    util;
   } util_result_type;

   class util_scoreboard_type;
      snapshot_type    prev_snap [DEFAULT_NUM_CPUS];
      util_result_type util_q [$];
      int unsigned     mismatches;
      int unsigned     results_seen;

      function new();
         foreach (prev_snap[k]) prev_snap[k] = '0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return util_q.size();
      endfunction

      // Difference against the stored snapshot, then busy share of total.
      function void note_snapshot(logic [CPU_IDX_W-1:0] cpu, snapshot_type snap);
         logic [CNT_W-1:0]   delta [NUM_COUNTERS];
         logic [CNT_W-1:0]   busy;
         logic [CNT_W-1:0]   total;
         logic [2*CNT_W-1:0] scaled;
         logic [2*CNT_W-1:0] quotient;
         util_result_type    res;
         if (int'(cpu) >= DEFAULT_NUM_CPUS) return;
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            delta[i] = snap[i] - prev_snap[cpu][i];
         end
         prev_snap[cpu] = snap;
         busy = delta[C_USER] + delta[C_NICE] + delta[C_SYSTEM] + delta[C_IRQ]
              + delta[C_SOFTIRQ] + delta[C_GUEST] + delta[C_NICE_GUEST];
         total = busy + delta[C_IDLE] + delta[C_IOWAIT] + delta[C_STEAL];
         res.cpu = cpu;
         if (total == '0 || busy == '0) begin
            res.util = '0;
         end else if (busy >= total) begin
            res.util = FULL_SCALE;
         end else begin
            scaled   = {{CNT_W{1'b0}}, busy} * (2*CNT_W)'(FULL_SCALE);
            quotient = scaled / {{CNT_W{1'b0}}, total};
            res.util = (quotient > (2*CNT_W)'(FULL_SCALE)) ? FULL_SCALE
                                                           : quotient[UTIL_W-1:0];
         end
         util_q.push_back(res);
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] beat);
         util_result_type      want;
         logic [CPU_IDX_W-1:0] got_cpu;
         logic [UTIL_W-1:0]    got_util;
         got_cpu  = beat[CPU_IDX_W-1:0];
         got_util = beat[CPU_IDX_W +: UTIL_W];
         results_seen++;
         if (util_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %0d: cpu %0d util %0d",
                        results_seen, got_cpu, got_util);
         end else begin
            want = util_q.pop_front();
            if (got_cpu !== want.cpu || got_util !== want.util) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected cpu %0d util %0d, got cpu %0d util %0d",
                           results_seen, want.cpu, want.util, got_cpu, got_util);
            end
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   util_scoreboard_type sb = new();
   snapshot_type   live [DEFAULT_NUM_CPUS] = '{default: '0};
   bit             req_calm = 1'b0;
   bit             rsp_calm = 1'b0;
   int unsigned    cycles   = 0;

   cpu_utilization_from_counters u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   function automatic int draw_wait(bit calm);
      return calm ? 0 : int'($urandom_range(0, 8));
   endfunction

   function automatic logic [CNT_W-1:0] draw_step(int unsigned scale);
      case (scale)
         0:       return CNT_W'($urandom_range(0, 50));
         1:       return CNT_W'($urandom_range(0, 100000));
         2:       return CNT_W'($urandom);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Move one processor's counters on: mostly steady growth, some odd shapes.
   function automatic void advance_counters(int unsigned cpu);
      int unsigned kind;
      int unsigned scale;
      bit          idle_slot;
      kind  = $urandom_range(0, 99);
      scale = $urandom_range(0, 2);
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         idle_slot = (i == C_IDLE || i == C_IOWAIT || i == C_STEAL);
         if (kind < 60)
            live[cpu][i] += draw_step(scale);
         else if (kind < 70)
            live[cpu][i] += $urandom_range(0, 1) ? draw_step(scale) : '0;
         else if (kind < 75)
            live[cpu][i] += idle_slot ? '0 : draw_step(scale);
         else if (kind < 79)
            live[cpu][i] += idle_slot ? draw_step(scale) : '0;
         else if (kind < 82)
            live[cpu][i] = live[cpu][i];
         else if (kind < 92)
            live[cpu][i] = {$urandom, $urandom};
         else
            live[cpu][i] += draw_step(3) >> $urandom_range(0, 4);
      end
   endfunction

   task automatic send_snapshot(input logic [CPU_IDX_W-1:0] cpu);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-CPU_IDX_W-COUNTERS_W){1'b0}}, live[cpu], cpu};
      do @(posedge clock); while (!req_tready);
      sb.note_snapshot(cpu, live[cpu]);
   endtask

   // Hold the sender until every pending result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : result_sink
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   initial begin : stimulus
      int unsigned cpu;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // first snapshot of a processor counts from zero: total is zero
      send_snapshot(6'd0);
      // all counters at their top: wrapped busy passes total
      live[63] = '1;
      send_snapshot(6'd63);
      live[0][C_IDLE] += 64'd100;
      send_snapshot(6'd0);
      live[0][C_USER] += 64'd100;
      send_snapshot(6'd0);
      // each counter moving on its own
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         live[5][i] += 64'd1;
         send_snapshot(6'd5);
      end
      for (int i = 0; i < NUM_COUNTERS; i++) live[5][i] += 64'd1;
      send_snapshot(6'd5);
      // product needs the full width
      live[7][C_USER] = 64'h7FFF_FFFF_FFFF_FFFF;
      live[7][C_IDLE] = 64'h8000_0000_0000_0000;
      send_snapshot(6'd7);
      // counters wrap through zero
      for (int i = 0; i < NUM_COUNTERS; i++) live[8][i] = 64'hFFFF_FFFF_FFFF_FFF0;
      send_snapshot(6'd8);
      for (int i = 0; i < NUM_COUNTERS; i++) live[8][i] += 64'h20;
      send_snapshot(6'd8);
      // idle runs backward, so busy exceeds total
      live[9][C_USER] += 64'd5;
      live[9][C_IDLE] -= 64'd1;
      send_snapshot(6'd9);
      live[10][C_USER]  = 64'd1;
      live[10][C_STEAL] = 64'hFFFF_FFFF_FFFF_FFFD;
      send_snapshot(6'd10);
      for (int i = 0; i < NUM_COUNTERS; i++)
         live[33][i] = (i % 2 != 0) ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555;
      send_snapshot(6'd33);
      drain();

      for (int b = 0; b < RAND_BLOCKS; b++) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            // favor a few processors so their histories run long
            cpu = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 63);
            advance_counters(cpu);
            send_snapshot(cpu[CPU_IDX_W-1:0]);
         end
         if (b == RAND_BLOCKS / 2) drain();
      end

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/cpuu_pkg.sv
rtl/cpuu_store.sv
rtl/cpuu_serial.sv
rtl/cpuu_divider.sv
rtl/cpu_utilization_from_counters.sv
test/tb.sv
